### sv/ppst_pkg.sv
// Package for the plane point/segment test: widths and the payload types.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none
package ppst_pkg;
  localparam int CB = 32;             // coordinate bits
  localparam int FB = 16;             // fraction bits
  localparam int TB = 16;             // tolerance bits
  localparam int NUM_REGS = 7;
  localparam int IDXW = 3;
  localparam int DW = CB + 1;         // coordinate difference
  localparam int PW = DW + CB;        // one product
  localparam int SW = PW + 2;         // sum of three products
  localparam int RW = SW + CB;        // divider remainder

  typedef enum logic [IDXW-1:0] {
    REG_NORMAL_X = 3'd0,
    REG_NORMAL_Y = 3'd1,
    REG_NORMAL_Z = 3'd2,
    REG_ANCHOR_X = 3'd3,
    REG_ANCHOR_Y = 3'd4,
    REG_ANCHOR_Z = 3'd5,
    REG_TOLERANCE = 3'd6
  } reg_idx_t;

  localparam logic [1:0] SIDE_ON = 2'd0;
  localparam logic [1:0] SIDE_INSIDE = 2'd1;
  localparam logic [1:0] SIDE_OUTSIDE = 2'd2;
endpackage
`default_nettype wire

### sv/ppst_if.sv
// Request channels of the plane point/segment test: input, result, config.
// Depends on ppst_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface ppst_in_if;
  import ppst_pkg::*;
  logic valid;
  logic ready;
  logic kind;
  logic signed [CB-1:0] first_x;
  logic signed [CB-1:0] first_y;
  logic signed [CB-1:0] first_z;
  logic signed [CB-1:0] second_x;
  logic signed [CB-1:0] second_y;
  logic signed [CB-1:0] second_z;
  modport source (output valid, kind, first_x, first_y, first_z,
                  second_x, second_y, second_z, input ready);
  modport sink (input valid, kind, first_x, first_y, first_z,
                second_x, second_y, second_z, output ready);
endinterface

interface ppst_out_if;
  import ppst_pkg::*;
  logic valid;
  logic ready;
  logic signed [CB-1:0] signed_distance;
  logic [1:0] side;
  logic hit;
  logic signed [CB-1:0] crossing_time;
  logic saturated;
  modport source (output valid, signed_distance, side, hit, crossing_time,
                  saturated, input ready);
  modport sink (input valid, signed_distance, side, hit, crossing_time,
                saturated, output ready);
endinterface

interface ppst_cfg_if;
  import ppst_pkg::*;
  logic valid;
  logic ready;
  logic [IDXW-1:0] index;
  logic [CB-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### sv/plane_point_segment_test.sv
// Plane point/segment test, top level: config registers, arithmetic pipeline
// and a bit-per-stage divider. Depends on ppst_pkg and the ppst_if interfaces.
`timescale 1ns / 1ps
`default_nettype none
// One result per request, one request accepted per cycle unless the output
// stalls. The pipeline has six arithmetic stages (differences, products,
// dot sums, magnitudes, square partials, parallel test), one divider stage
// per quotient bit, and the output register. The whole pipeline stalls as
// one while a result waits at the output; no request is lost or repeated.
// Config writes are always taken and must only be made while the pipeline
// is empty.
module plane_point_segment_test (
  input  wire           clk,
  input  wire           rst_n,
  ppst_in_if.sink       in_if,
  ppst_out_if.source    out_if,
  ppst_cfg_if.sink      cfg_if
);
  import ppst_pkg::*;

  // ---------------- config registers ----------------
  logic signed [CB-1:0] nrm_r [3];
  logic signed [CB-1:0] anc_r [3];
  logic [TB-1:0] tol_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrm_r[0] <= '0;
      nrm_r[1] <= CB'(1) << FB;
      nrm_r[2] <= '0;
      anc_r[0] <= '0;
      anc_r[1] <= '0;
      anc_r[2] <= '0;
      tol_r <= TB'(66);
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_NORMAL_X: nrm_r[0] <= cfg_if.data;
        REG_NORMAL_Y: nrm_r[1] <= cfg_if.data;
        REG_NORMAL_Z: nrm_r[2] <= cfg_if.data;
        REG_ANCHOR_X: anc_r[0] <= cfg_if.data;
        REG_ANCHOR_Y: anc_r[1] <= cfg_if.data;
        REG_ANCHOR_Z: anc_r[2] <= cfg_if.data;
        REG_TOLERANCE: tol_r <= cfg_if.data[TB-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic out_valid_r;
  logic adv;
  assign adv = !out_valid_r || out_if.ready;
  assign in_if.ready = adv;

  logic [5:0] sv_r;   // valid bits of stages 1..6

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
    end else if (adv) begin
      sv_r <= {sv_r[4:0], in_if.valid};
    end
  end

  // ---------------- stage 1: differences ----------------
  logic kind1_r;
  logic signed [DW-1:0] pd1_r [3];
  logic signed [DW-1:0] v1_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      kind1_r <= in_if.kind;
      pd1_r[0] <= DW'(in_if.first_x) - DW'(anc_r[0]);
      pd1_r[1] <= DW'(in_if.first_y) - DW'(anc_r[1]);
      pd1_r[2] <= DW'(in_if.first_z) - DW'(anc_r[2]);
      v1_r[0] <= DW'(in_if.second_x) - DW'(in_if.first_x);
      v1_r[1] <= DW'(in_if.second_y) - DW'(in_if.first_y);
      v1_r[2] <= DW'(in_if.second_z) - DW'(in_if.first_z);
    end
  end

  // ---------------- stage 2: products ----------------
  logic kind2_r;
  logic signed [PW-1:0] pn2_r [3];
  logic signed [PW-1:0] vn2_r [3];
  logic [PW-1:0] vv2_r [3];
  logic [2*TB-1:0] e2_2_r;
  logic signed [PW:0] sq [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq[i] = v1_r[i] * v1_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind2_r <= kind1_r;
      for (int i = 0; i < 3; i++) begin
        pn2_r[i] <= pd1_r[i] * nrm_r[i];
        vn2_r[i] <= v1_r[i] * nrm_r[i];
        vv2_r[i] <= sq[i][PW-1:0];
      end
      e2_2_r <= tol_r * tol_r;
    end
  end

  // ---------------- stage 3: dot sums ----------------
  logic kind3_r;
  logic signed [SW-1:0] d3_r;
  logic signed [SW-1:0] m3_r;
  logic [SW-1:0] l3_r;
  logic [2*TB-1:0] e2_3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      kind3_r <= kind2_r;
      d3_r <= SW'(pn2_r[0]) + SW'(pn2_r[1]) + SW'(pn2_r[2]);
      m3_r <= SW'(vn2_r[0]) + SW'(vn2_r[1]) + SW'(vn2_r[2]);
      l3_r <= SW'(vv2_r[0]) + SW'(vv2_r[1]) + SW'(vv2_r[2]);
      e2_3_r <= e2_2_r;
    end
  end

  // ---------------- stage 4: magnitudes, side, distance ----------------
  logic signed [SW-1:0] eps_s;
  logic signed [SW-FB-1:0] dsh;
  logic dfit;
  assign eps_s = SW'({tol_r, FB'(0)});
  assign dsh = d3_r[SW-1:FB];
  assign dfit = (dsh[SW-FB-1:CB-1] == '0) || (dsh[SW-FB-1:CB-1] == '1);

  logic kind4_r, degen4_r, mzero4_r, close4_r, neg4_r, satd4_r;
  logic [1:0] side4_r;
  logic signed [CB-1:0] dist4_r;
  logic [SW-1:0] absd4_r, absm4_r, l4_r;
  logic [2*TB-1:0] e2_4_r;
  logic [SW-1:0] absd_c;
  assign absd_c = d3_r[SW-1] ? SW'(-d3_r) : SW'(d3_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      kind4_r <= kind3_r;
      if (d3_r > eps_s) side4_r <= SIDE_INSIDE;
      else if (d3_r < -eps_s) side4_r <= SIDE_OUTSIDE;
      else side4_r <= SIDE_ON;
      // floored distance, clamped
      satd4_r <= !dfit;
      if (dfit) dist4_r <= dsh[CB-1:0];
      else if (dsh[SW-FB-1]) dist4_r <= {1'b1, {(CB-1){1'b0}}};
      else dist4_r <= {1'b0, {(CB-1){1'b1}}};
      absd4_r <= absd_c;
      close4_r <= absd_c < SW'({tol_r, FB'(0)});
      absm4_r <= m3_r[SW-1] ? SW'(-m3_r) : SW'(m3_r);
      mzero4_r <= m3_r == '0;
      // quotient sign: numerator is -d
      neg4_r <= (d3_r > 0) ^ m3_r[SW-1];
      degen4_r <= (l3_r == '0) || (l3_r < SW'(e2_3_r));
      l4_r <= l3_r;
      e2_4_r <= e2_3_r;
    end
  end

  // ---------------- stage 5: square partials, overflow check ----------------
  logic [CB-1:0] mh, ml;
  assign mh = absm4_r[2*CB-1:CB];
  assign ml = absm4_r[CB-1:0];

  logic kind5_r, degen5_r, mzero5_r, close5_r, neg5_r, satd5_r, mfit5_r, ovf5_r;
  logic [1:0] side5_r;
  logic signed [CB-1:0] dist5_r;
  logic [2*CB-1:0] hh5_r, hl5_r, ll5_r;
  logic [CB+2*TB-1:0] lel5_r;
  logic [SW-CB+2*TB-1:0] leh5_r;
  logic [RW-1:0] u5_r;
  logic [SW-1:0] dd5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      kind5_r <= kind4_r;
      degen5_r <= degen4_r;
      mzero5_r <= mzero4_r;
      close5_r <= close4_r;
      neg5_r <= neg4_r;
      satd5_r <= satd4_r;
      side5_r <= side4_r;
      dist5_r <= dist4_r;
      mfit5_r <= absm4_r[SW-1:2*CB] == '0;
      hh5_r <= mh * mh;
      hl5_r <= mh * ml;
      ll5_r <= ml * ml;
      lel5_r <= l4_r[CB-1:0] * e2_4_r;
      leh5_r <= l4_r[SW-1:CB] * e2_4_r;
      u5_r <= RW'(absd4_r) << FB;
      ovf5_r <= (RW'(absd4_r) << FB) >= (RW'(absm4_r) << CB);
      dd5_r <= absm4_r;
    end
  end

  // ---------------- stage 6: parallel test, divider setup ----------------
  logic [4*CB-1:0] msq, lep;
  logic par;
  assign msq = ((4*CB)'(hh5_r) << (2*CB)) + ((4*CB)'(hl5_r) << (CB+1))
             + (4*CB)'(ll5_r);
  assign lep = (4*CB)'(lel5_r) + ((4*CB)'(leh5_r) << CB);
  assign par = mfit5_r && (mzero5_r || (msq < lep));

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [SW-1:0] dvs;
    logic [CB-1:0] quo;
    logic neg;
    logic ovf;
    logic dodiv;
    logic hit;
    logic satd;
    logic [1:0] side;
    logic [CB-1:0] sdist;
  } div_t;

  div_t dv_r [CB+1];
  logic [CB-1:0] dvv_r;   // valid bits of divider stages 1..CB

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0].rem <= u5_r;
      dv_r[0].dvs <= dd5_r;
      dv_r[0].quo <= '0;
      dv_r[0].neg <= neg5_r;
      dv_r[0].ovf <= ovf5_r;
      dv_r[0].dodiv <= kind5_r && !degen5_r && !par;
      dv_r[0].hit <= kind5_r && !degen5_r && (!par || close5_r);
      dv_r[0].satd <= satd5_r;
      dv_r[0].side <= side5_r;
      dv_r[0].sdist <= dist5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvv_r <= '0;
    end else if (adv) begin
      dvv_r <= {dvv_r[CB-2:0], sv_r[5]};
    end
  end

  // ---------------- divider: one quotient bit per stage ----------------
  for (genvar g = 0; g < CB; g++) begin : g_div
    localparam int B = CB - 1 - g;
    logic [RW-1:0] sub;
    logic take;
    div_t nxt;
    assign sub = RW'(dv_r[g].dvs) << B;
    assign take = dv_r[g].rem >= sub;
    always_comb begin
      nxt = dv_r[g];
      if (take) begin
        nxt.rem = dv_r[g].rem - sub;
        nxt.quo[B] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[g+1] <= nxt;
      end
    end
  end

  // ---------------- output: sign, clamp ----------------
  div_t fin;
  logic tsat;
  logic signed [CB-1:0] tval;
  assign fin = dv_r[CB];

  always_comb begin
    tsat = fin.ovf || (fin.neg ? (fin.quo > {1'b1, {(CB-1){1'b0}}}) : fin.quo[CB-1]);
    if (!fin.dodiv) tval = '0;
    else if (tsat) tval = fin.neg ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
    else tval = fin.neg ? -fin.quo : fin.quo;
  end

  logic signed [CB-1:0] dist_r, time_r;
  logic [1:0] side_r;
  logic hit_r, sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dvv_r[CB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dist_r <= fin.sdist;
      side_r <= fin.side;
      hit_r <= fin.hit;
      time_r <= tval;
      sat_r <= fin.satd || (fin.dodiv && tsat);
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.signed_distance = dist_r;
  assign out_if.side = side_r;
  assign out_if.hit = hit_r;
  assign out_if.crossing_time = time_r;
  assign out_if.saturated = sat_r;
endmodule
`default_nettype wire

### tb/ppst_checker.sv
// Checker for the plane point/segment test: watches the request, result and
// config channels, predicts each result and compares it. Depends on ppst_pkg, ppst_if.
`timescale 1ns / 1ps
module ppst_checker (
  input  logic  clk,
  input  logic  rst_n,
  ppst_in_if    in_ch,
  ppst_out_if   out_ch,
  ppst_cfg_if   cfg_ch,
  output int    fails,
  output int    pending
);
  import ppst_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic signed [CB-1:0] sdist;
    logic [1:0]           side;
    logic                 hit;
    logic signed [CB-1:0] t;
    logic                 sat;
  } plane_result_t;

  // plane registers as seen through the config channel
  logic signed [CB-1:0] nrm [3];
  logic signed [CB-1:0] anc [3];
  logic [TB-1:0]        tol;

  plane_result_t expected_results[$];

  function automatic wide_t dot3(longint x, longint y, longint z,
                                 longint ex, longint ey, longint ez);
    wide_t wx, wy, wz, vx, vy, vz;
    wx = x; wy = y; wz = z; vx = ex; vy = ey; vz = ez;
    return wx * vx + wy * vy + wz * vz;
  endfunction

  function automatic logic signed [CB-1:0] clamp_coord(wide_t v, inout logic flag);
    wide_t hi, lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      flag = 1'b1;
      return hi[CB-1:0];
    end
    if (v < lo) begin
      flag = 1'b1;
      return lo[CB-1:0];
    end
    return v[CB-1:0];
  endfunction

  function automatic plane_result_t predict_plane(
      logic kind, logic signed [CB-1:0] ax, logic signed [CB-1:0] ay,
      logic signed [CB-1:0] az, logic signed [CB-1:0] bx,
      logic signed [CB-1:0] by, logic signed [CB-1:0] bz);
    plane_result_t r;
    wide_t d, eps, l2, m, num, am, e2, anum;
    logic [127:0] mm, lim;
    logic sat, par;
    longint vx, vy, vz;
    sat = 1'b0;
    r = '0;
    eps = {96'd0, tol, 16'd0};
    d = dot3(longint'(ax) - longint'(anc[0]), longint'(ay) - longint'(anc[1]),
             longint'(az) - longint'(anc[2]), nrm[0], nrm[1], nrm[2]);
    if (d > eps) r.side = SIDE_INSIDE;
    else if (d < -eps) r.side = SIDE_OUTSIDE;
    else r.side = SIDE_ON;
    r.sdist = clamp_coord(d >>> FB, sat);
    if (kind) begin
      vx = longint'(bx) - longint'(ax);
      vy = longint'(by) - longint'(ay);
      vz = longint'(bz) - longint'(az);
      e2 = {96'd0, 32'(tol) * 32'(tol)};
      l2 = dot3(vx, vy, vz, vx, vy, vz);
      m = dot3(vx, vy, vz, nrm[0], nrm[1], nrm[2]);
      num = -d;
      // degenerate segments never hit
      if (!(l2 == 0 || l2 < e2)) begin
        am = (m < 0) ? -m : m;
        if (am[127:64] != 0) par = 1'b0;
        else if (am == 0) par = 1'b1;
        else begin
          mm = am * am;
          lim = l2 * e2;
          par = mm < lim;
        end
        if (par) begin
          // parallel: a hit only when the segment lies in the plane
          anum = (num < 0) ? -num : num;
          if (anum < eps) r.hit = 1'b1;
        end else begin
          r.hit = 1'b1;
          r.t = clamp_coord((num <<< FB) / m, sat);
        end
      end
    end
    r.sat = sat;
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    fails++;
  endtask

  assign pending = expected_results.size();

  always @(posedge clk) begin
    plane_result_t e;
    if (!rst_n) begin
      nrm[0] <= 0; nrm[1] <= 32'sd65536; nrm[2] <= 0;
      anc[0] <= 0; anc[1] <= 0; anc[2] <= 0;
      tol <= 16'd66;
    end else begin
      // register writes
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_NORMAL_X:  nrm[0] <= cfg_ch.data;
          REG_NORMAL_Y:  nrm[1] <= cfg_ch.data;
          REG_NORMAL_Z:  nrm[2] <= cfg_ch.data;
          REG_ANCHOR_X:  anc[0] <= cfg_ch.data;
          REG_ANCHOR_Y:  anc[1] <= cfg_ch.data;
          REG_ANCHOR_Z:  anc[2] <= cfg_ch.data;
          REG_TOLERANCE: tol <= cfg_ch.data[TB-1:0];
          default: ;
        endcase
      end
      // accepted requests
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(predict_plane(in_ch.kind, in_ch.first_x,
          in_ch.first_y, in_ch.first_z, in_ch.second_x, in_ch.second_y,
          in_ch.second_z));
      // results
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result", $realtime);
          fails++;
        end else begin
          e = expected_results.pop_front();
          if (out_ch.signed_distance !== e.sdist)
            report("signed_distance", out_ch.signed_distance, e.sdist);
          if (out_ch.side !== e.side) report("side", out_ch.side, e.side);
          if (out_ch.hit !== e.hit) report("hit", out_ch.hit, e.hit);
          if (out_ch.crossing_time !== e.t)
            report("crossing_time", out_ch.crossing_time, e.t);
          if (out_ch.saturated !== e.sat) report("saturated", out_ch.saturated, e.sat);
        end
      end
    end
  end
endmodule

### tb/tb_plane_point_segment_test.sv
// Testbench top for the plane point/segment test: clock, reset, stimulus and
// verdict. Depends on ppst_pkg, ppst_if, ppst_checker and the block.
`timescale 1ns / 1ps
module tb_plane_point_segment_test;
  import ppst_pkg::*;

  localparam int LATENCY = 6 + CB + 1;
  localparam int STALL_LIMIT = 3000;
  localparam int ONE = 65536;
  localparam int QUIET_AFTER = 1550;
  localparam logic [IDXW-1:0] REG_UNUSED = 3'd7;

  logic clk;
  logic rst_n;
  int   fails, pending, sent, idle_cnt;
  bit   long_hold, hold_done, quiet;

  ppst_in_if  in_if ();
  ppst_out_if out_if ();
  ppst_cfg_if cfg_if ();

  plane_point_segment_test uut (.clk(clk), .rst_n(rst_n), .in_if(in_if.sink),
    .out_if(out_if.source), .cfg_if(cfg_if.sink));

  ppst_checker chk (.clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .cfg_ch(cfg_if), .fails(fails), .pending(pending));

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // watchdog: cycles with no request moving on any channel
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: short random stalls, one long hold-off on request
  always begin
    @(negedge clk);
    if (long_hold && !hold_done) begin
      out_if.ready <= 1'b0;
      repeat (200) @(negedge clk);
      hold_done = 1'b1;
      out_if.ready <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_if.ready <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  task automatic write_reg(logic [IDXW-1:0] idx, logic [CB-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send(logic kind, int ax, int ay, int az, int bx, int by, int bz);
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.kind <= kind;
    in_if.first_x <= ax; in_if.first_y <= ay; in_if.first_z <= az;
    in_if.second_x <= bx; in_if.second_y <= by; in_if.second_z <= bz;
    do @(posedge clk); while (!in_if.ready);
    sent++;
    quiet = sent > QUIET_AFTER;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat ($urandom_range(0, 2)) @(negedge clk);
    end
  endtask

  // drain the pipeline before touching the registers
  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic set_plane(int nx, int ny, int nz, int qx, int qy, int qz, int t);
    drain();
    write_reg(REG_NORMAL_X, nx);
    write_reg(REG_NORMAL_Y, ny);
    write_reg(REG_NORMAL_Z, nz);
    write_reg(REG_ANCHOR_X, qx);
    write_reg(REG_ANCHOR_Y, qy);
    write_reg(REG_ANCHOR_Z, qz);
    write_reg(REG_TOLERANCE, t);
  endtask

  function automatic int coord(int style);
    case (style)
      0: return $urandom;
      1: return $urandom_range(0, 2 * ONE) - ONE;
      default: return $urandom_range(0, 20 * ONE) - 10 * ONE;
    endcase
  endfunction

  task automatic directed_items();
    int mx, mn;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    send(1'b0, 0, 0, 0, 0, 0, 0);
    send(1'b0, mx, mx, mx, 0, 0, 0);
    send(1'b0, mn, mn, mn, mx, mx, mx);
    send(1'b0, 0, 66, 0, 0, 0, 0);
    send(1'b0, 0, -67, 0, 0, 0, 0);
    // degenerate: zero length and tiny length
    send(1'b1, ONE, ONE, ONE, ONE, ONE, ONE);
    send(1'b1, ONE, ONE, ONE, ONE + 1, ONE, ONE);
    // crossing, in plane, parallel off plane
    send(1'b1, ONE, -ONE, 3 * ONE, -ONE, 2 * ONE, ONE);
    send(1'b1, 0, 0, 0, 5 * ONE, 0, 3 * ONE);
    send(1'b1, 0, ONE, 0, 5 * ONE, ONE, 0);
    // saturation both ways and nearly parallel long segment
    send(1'b1, mn, mn, mn, mx, mx, mx);
    send(1'b1, mx, mx, mx, mn, mn, mn);
    send(1'b1, mn, 10, mn, mx, 11, mx);
    send(1'b1, 0, ONE, 0, 0, ONE + 1, 0);
  endtask

  task automatic random_items(int count);
    int style, ax, ay, az, bx, by, bz;
    for (int i = 0; i < count; i++) begin
      style = $urandom_range(0, 9);
      ax = coord(style); ay = coord(style); az = coord(style);
      case ($urandom_range(0, 9))
        0: begin bx = ax; by = ay; bz = az; end
        1: begin bx = ax + $urandom_range(0, 3); by = ay; bz = az; end
        2: begin bx = coord(0); by = coord(0); bz = coord(0); end
        default: begin bx = coord(style); by = coord(style); bz = coord(style); end
      endcase
      send(1'($urandom_range(0, 1)), ax, ay, az, bx, by, bz);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    long_hold = 1'b0;
    quiet = 1'b0;
    sent = 0;
    in_if.valid = 1'b0;
    in_if.kind = 1'b0;
    in_if.first_x = 0; in_if.first_y = 0; in_if.first_z = 0;
    in_if.second_x = 0; in_if.second_y = 0; in_if.second_z = 0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_NORMAL_X;
    cfg_if.data = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset plane
    directed_items();
    random_items(200);
    long_hold = 1'b1;
    random_items(150);

    set_plane(ONE, 0, 0, ONE, 0, 0, 0);
    write_reg(REG_UNUSED, 32'hffffffff);
    directed_items();
    random_items(250);

    set_plane(0, 0, -ONE, 0, 0, -3 * ONE, 65535);
    random_items(250);

    set_plane(37837, 37837, 37837, 2 * ONE, -ONE, 5 * ONE, 66);
    directed_items();
    random_items(300);

    set_plane(32'h7fffffff, 32'h80000000, 32'h80000000,
              32'h7fffffff, 32'h80000000, 32'h7fffffff, 65535);
    directed_items();
    random_items(150);

    set_plane(0, ONE, 0, 0, 0, 0, 1);
    random_items(400);

    @(negedge clk);
    in_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (fails == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

### files.f
sv/ppst_pkg.sv
sv/ppst_if.sv
sv/plane_point_segment_test.sv
tb/ppst_checker.sv
tb/tb_plane_point_segment_test.sv
